// File: design/qes_pkg.sv
package qes_pkg;

    // Result field widths, fixed by the Q16.16 root format.
    localparam int ROOT_WIDTH   = 32;
    localparam int STATUS_WIDTH = 2;

    // Fraction bits added to a Q8.8 numerator so that num / (2a) lands in Q16.16.
    localparam int QUOT_SHIFT = 15;

    // Status codes.
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_A_ZERO = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_SAT    = 2'd2;

endpackage

// File: design/qes_coef_if.sv
interface qes_coef_if #(
    parameter int COEF_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// File: design/qes_root_if.sv
interface qes_root_if;
    import qes_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [ROOT_WIDTH-1:0]   first_root_real;
    logic signed [ROOT_WIDTH-1:0]   first_root_imag;
    logic signed [ROOT_WIDTH-1:0]   second_root_real;
    logic signed [ROOT_WIDTH-1:0]   second_root_imag;
    logic                           complex_pair;
    logic        [STATUS_WIDTH-1:0] status;

    modport source (
        output valid, output first_root_real, output first_root_imag,
        output second_root_real, output second_root_imag,
        output complex_pair, output status, input ready
    );
    modport sink (
        input valid, input first_root_real, input first_root_imag,
        input second_root_real, input second_root_imag,
        input complex_pair, input status, output ready
    );
endinterface

// File: design/quadratic_equation_solver_unit.sv
// Quadratic root solver. Each transaction on coef carries a, b and c of a*x^2 + b*x + c
// as signed Q8.8 values; each transaction on roots returns both roots in signed Q16.16,
// as real roots or as a conjugate pair, with division truncated toward zero and results
// saturated to 32 bits. A new coefficient triple is taken every cycle unless the
// pipeline holds. Three stages form the discriminant, a square-root pipeline retires
// one root bit per stage (COEF_WIDTH + 1 stages), one stage forms the numerators, two
// restoring dividers share a pipeline that retires one quotient bit per stage
// (COEF_WIDTH + 17 stages), and one stage saturates into the output register.
// When roots is stalled with a result waiting, the whole pipeline holds.
module quadratic_equation_solver_unit #(
    parameter int COEF_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    qes_coef_if.sink        coef,
    qes_root_if.source      roots
);
    import qes_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int SW  = W + 1;                 // square root width
    localparam int RW  = SW + 3;                // square root remainder width
    localparam int NS  = W + 3;                 // signed numerator width
    localparam int NW  = W + 2;                 // numerator magnitude width
    localparam int DVW = NW + QUOT_SHIFT;       // dividend and quotient width
    localparam int QX  = (DVW > ROOT_WIDTH + 1) ? DVW : ROOT_WIDTH + 1;

    typedef struct packed {
        logic                a_zero;
        logic                a_neg;
        logic [W-1:0]        a_mag;
        logic signed [W-1:0] b;
        logic                disc_neg;
    } side_t;

    typedef struct packed {
        logic         a_zero;
        logic         complex_pair;
        logic         sgn1;
        logic         sgn2;
        logic [W-1:0] d;
    } dside_t;

    // Saturate a quotient magnitude with its sign; the top bit flags saturation.
    function automatic logic [ROOT_WIDTH:0] sat_root(input logic [QX-1:0] q, input logic neg);
        logic [QX-1:0] lim;
        logic [QX-1:0] m;
        logic          over;
        lim  = neg ? (QX'(1) << (ROOT_WIDTH - 1)) : ((QX'(1) << (ROOT_WIDTH - 1)) - QX'(1));
        over = q > lim;
        m    = over ? lim : q;
        return {over, neg ? (ROOT_WIDTH'(0) - m[ROOT_WIDTH-1:0]) : m[ROOT_WIDTH-1:0]};
    endfunction

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : W'(x);
    endfunction

    // Global advance: everything moves unless a result waits on a stalled sink.
    logic en;
    logic out_v_reg;
    assign en         = !out_v_reg || roots.ready;
    assign coef.ready = en;

    // Stage 0: capture the coefficients.
    logic                s0_v_reg;
    logic signed [W-1:0] s0_a_reg, s0_b_reg, s0_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= coef.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_a_reg <= coef.coef_a;
            s0_b_reg <= coef.coef_b;
            s0_c_reg <= coef.coef_c;
        end
    end

    // Stage 1: b*b and |a|*|c|.
    logic           s1_v_reg;
    side_t          s1_side_reg;
    side_t          s1_side_next;
    logic [2*W-1:0] s1_bsq_reg, s1_ac_reg;
    logic           s1_same_reg;
    logic [W-1:0]   s0_b_mag, s0_c_mag;

    always_comb
    begin
        s0_b_mag              = mag_w(s0_b_reg);
        s0_c_mag              = mag_w(s0_c_reg);
        s1_side_next.a_zero   = (s0_a_reg == '0);
        s1_side_next.a_neg    = s0_a_reg[W-1];
        s1_side_next.a_mag    = mag_w(s0_a_reg);
        s1_side_next.b        = s0_b_reg;
        s1_side_next.disc_neg = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s1_bsq_reg  <= s0_b_mag * s0_b_mag;
            s1_ac_reg   <= s1_side_next.a_mag * s0_c_mag;
            s1_same_reg <= (s0_c_reg != '0) && (s0_a_reg[W-1] == s0_c_reg[W-1]);
        end
    end

    // Stage 2: discriminant magnitude and sign.
    logic            s2_v_reg;
    side_t           s2_side_reg;
    side_t           s2_side_next;
    logic [2*SW-1:0] s2_disc_reg, s2_disc_next;
    logic [2*SW-1:0] bsq_x, fourac_x;

    always_comb
    begin
        bsq_x        = (2*SW)'(s1_bsq_reg);
        fourac_x     = {s1_ac_reg, 2'b00};
        s2_side_next = s1_side_reg;
        if (s1_same_reg)
        begin
            if (bsq_x < fourac_x)
            begin
                s2_side_next.disc_neg = 1'b1;
                s2_disc_next          = fourac_x - bsq_x;
            end
            else
            begin
                s2_disc_next = bsq_x - fourac_x;
            end
        end
        else
        begin
            s2_disc_next = bsq_x + fourac_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s2_side_next;
            s2_disc_reg <= s2_disc_next;
        end
    end

    // Square root pipeline: one root bit per stage.
    logic            sq_v_reg    [SW];
    side_t           sq_side_reg [SW];
    logic [2*SW-1:0] sq_rad_reg  [SW];
    logic [RW-1:0]   sq_rem_reg  [SW];
    logic [SW-1:0]   sq_root_reg [SW];

    genvar k;
    generate
        for (k = 0; k < SW; k++)
        begin : g_sqrt
            logic            v_in;
            side_t           side_in;
            logic [2*SW-1:0] rad_in;
            logic [RW-1:0]   rem_in;
            logic [SW-1:0]   root_in;
            logic [RW-1:0]   rem_sh;
            logic [RW-1:0]   trial;
            logic [RW-1:0]   rem_next;
            logic [SW-1:0]   root_next;

            if (k == 0)
            begin : g_first
                assign v_in    = s2_v_reg;
                assign side_in = s2_side_reg;
                assign rad_in  = s2_disc_reg;
                assign rem_in  = '0;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign v_in    = sq_v_reg[k-1];
                assign side_in = sq_side_reg[k-1];
                assign rad_in  = sq_rad_reg[k-1];
                assign rem_in  = sq_rem_reg[k-1];
                assign root_in = sq_root_reg[k-1];
            end

            always_comb
            begin
                rem_sh = {rem_in[RW-3:0], rad_in[2*SW-1 -: 2]};
                trial  = RW'({root_in, 2'b01});
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_in[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_in[SW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    sq_v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_side_reg[k] <= side_in;
                    sq_rad_reg[k]  <= rad_in << 2;
                    sq_rem_reg[k]  <= rem_next;
                    sq_root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    // Numerator stage: choose the two dividends and the result signs.
    logic               nm_v_reg;
    dside_t             nm_side_reg, nm_side_next;
    logic [DVW-1:0]     nm_dv1_reg, nm_dv2_reg;
    logic [DVW-1:0]     nm_dv1_next, nm_dv2_next;
    side_t              sq_last;
    logic signed [NS-1:0] s_x, nb_x, n1, n2;
    logic [NS-1:0]      n1_mag, n2_mag;

    always_comb
    begin
        sq_last = sq_side_reg[SW-1];
        s_x     = signed'({2'b00, sq_root_reg[SW-1]});
        nb_x    = -signed'({{3{sq_last.b[W-1]}}, sq_last.b});
        if (sq_last.disc_neg)
        begin
            n1 = nb_x;
            n2 = s_x;
        end
        else
        begin
            n1 = nb_x + s_x;
            n2 = nb_x - s_x;
        end
        n1_mag = n1[NS-1] ? NS'(-n1) : NS'(n1);
        n2_mag = n2[NS-1] ? NS'(-n2) : NS'(n2);
        nm_dv1_next = {n1_mag[NW-1:0], {QUOT_SHIFT{1'b0}}};
        nm_dv2_next = {n2_mag[NW-1:0], {QUOT_SHIFT{1'b0}}};

        nm_side_next.a_zero       = sq_last.a_zero;
        nm_side_next.complex_pair = sq_last.disc_neg;
        nm_side_next.sgn1         = n1[NS-1] ^ sq_last.a_neg;
        // For a pair the second quotient is s/(2a), whose sign follows a.
        nm_side_next.sgn2         = sq_last.disc_neg ? sq_last.a_neg
                                                     : (n2[NS-1] ^ sq_last.a_neg);
        nm_side_next.d            = sq_last.a_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_v_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_v_reg <= sq_v_reg[SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_side_reg <= nm_side_next;
            nm_dv1_reg  <= nm_dv1_next;
            nm_dv2_reg  <= nm_dv2_next;
        end
    end

    // Divider pipeline: two restoring dividers, one quotient bit per stage.
    logic           dv_v_reg    [DVW];
    dside_t         dv_side_reg [DVW];
    logic [DVW-1:0] dv_qd1_reg  [DVW];
    logic [DVW-1:0] dv_qd2_reg  [DVW];
    logic [W-1:0]   dv_r1_reg   [DVW];
    logic [W-1:0]   dv_r2_reg   [DVW];

    genvar j;
    generate
        for (j = 0; j < DVW; j++)
        begin : g_div
            logic           v_in;
            dside_t         side_in;
            logic [DVW-1:0] qd1_in, qd2_in;
            logic [W-1:0]   r1_in, r2_in;
            logic [W:0]     r1_sh, r2_sh, dx;
            logic           ge1, ge2;
            logic [W:0]     r1_new, r2_new;

            if (j == 0)
            begin : g_first
                assign v_in    = nm_v_reg;
                assign side_in = nm_side_reg;
                assign qd1_in  = nm_dv1_reg;
                assign qd2_in  = nm_dv2_reg;
                assign r1_in   = '0;
                assign r2_in   = '0;
            end
            else
            begin : g_rest
                assign v_in    = dv_v_reg[j-1];
                assign side_in = dv_side_reg[j-1];
                assign qd1_in  = dv_qd1_reg[j-1];
                assign qd2_in  = dv_qd2_reg[j-1];
                assign r1_in   = dv_r1_reg[j-1];
                assign r2_in   = dv_r2_reg[j-1];
            end

            always_comb
            begin
                dx     = {1'b0, side_in.d};
                r1_sh  = {r1_in, qd1_in[DVW-1]};
                r2_sh  = {r2_in, qd2_in[DVW-1]};
                ge1    = r1_sh >= dx;
                ge2    = r2_sh >= dx;
                r1_new = ge1 ? (r1_sh - dx) : r1_sh;
                r2_new = ge2 ? (r2_sh - dx) : r2_sh;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    dv_v_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_side_reg[j] <= side_in;
                    dv_qd1_reg[j]  <= {qd1_in[DVW-2:0], ge1};
                    dv_qd2_reg[j]  <= {qd2_in[DVW-2:0], ge2};
                    dv_r1_reg[j]   <= r1_new[W-1:0];
                    dv_r2_reg[j]   <= r2_new[W-1:0];
                end
            end
        end
    endgenerate

    // Output stage: saturate, assemble and hold until taken.
    dside_t                  dl;
    logic [QX-1:0]           q1x, q2x;
    logic [ROOT_WIDTH:0]     r_fr, r_i1, r_i2, r_sr;
    logic [ROOT_WIDTH-1:0]   fr_next, fi_next, sr_next, si_next;
    logic [STATUS_WIDTH-1:0] st_next;
    logic                    cp_next, sat_any;
    logic [ROOT_WIDTH-1:0]   fr_reg, fi_reg, sr_reg, si_reg;
    logic [STATUS_WIDTH-1:0] st_reg;
    logic                    cp_reg;

    always_comb
    begin
        dl   = dv_side_reg[DVW-1];
        q1x  = QX'(dv_qd1_reg[DVW-1]);
        q2x  = QX'(dv_qd2_reg[DVW-1]);
        r_fr = sat_root(q1x, dl.sgn1);
        r_i1 = sat_root(q2x, dl.sgn2);
        r_i2 = sat_root(q2x, !dl.sgn2);
        r_sr = sat_root(q2x, dl.sgn2);
        if (dl.a_zero)
        begin
            fr_next = '0;
            fi_next = '0;
            sr_next = '0;
            si_next = '0;
            cp_next = 1'b0;
            sat_any = 1'b0;
        end
        else if (dl.complex_pair)
        begin
            fr_next = r_fr[ROOT_WIDTH-1:0];
            sr_next = r_fr[ROOT_WIDTH-1:0];
            fi_next = r_i1[ROOT_WIDTH-1:0];
            si_next = r_i2[ROOT_WIDTH-1:0];
            cp_next = 1'b1;
            sat_any = r_fr[ROOT_WIDTH] | r_i1[ROOT_WIDTH] | r_i2[ROOT_WIDTH];
        end
        else
        begin
            fr_next = r_fr[ROOT_WIDTH-1:0];
            sr_next = r_sr[ROOT_WIDTH-1:0];
            fi_next = '0;
            si_next = '0;
            cp_next = 1'b0;
            sat_any = r_fr[ROOT_WIDTH] | r_sr[ROOT_WIDTH];
        end
        if (dl.a_zero)
        begin
            st_next = STATUS_A_ZERO;
        end
        else if (sat_any)
        begin
            st_next = STATUS_SAT;
        end
        else
        begin
            st_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_v_reg[DVW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_reg <= fr_next;
            fi_reg <= fi_next;
            sr_reg <= sr_next;
            si_reg <= si_next;
            cp_reg <= cp_next;
            st_reg <= st_next;
        end
    end

    assign roots.valid            = out_v_reg;
    assign roots.first_root_real  = signed'(fr_reg);
    assign roots.first_root_imag  = signed'(fi_reg);
    assign roots.second_root_real = signed'(sr_reg);
    assign roots.second_root_imag = signed'(si_reg);
    assign roots.complex_pair     = cp_reg;
    assign roots.status           = st_reg;

    // A waiting result that is not taken must block new transactions.
    assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && !roots.ready |-> !coef.ready)
        else $error("coefficient accepted while a result is stalled");

    // A held result must not change while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && !roots.ready |=> $stable(roots.first_root_real)
            && $stable(roots.second_root_imag) && $stable(roots.status))
        else $error("stalled result changed");

    // A conjugate pair shares its real part and is never reported with a zero leading term.
    assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && roots.complex_pair |->
            roots.first_root_real == roots.second_root_real
            && roots.status != STATUS_A_ZERO)
        else $error("inconsistent conjugate pair");

    // A zero leading coefficient gives all-zero roots.
    assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && roots.status == STATUS_A_ZERO |->
            roots.first_root_real == '0 && roots.second_root_real == '0
            && roots.first_root_imag == '0 && roots.second_root_imag == '0)
        else $error("nonzero roots with zero leading coefficient");

endmodule

// File: bench/tb_channels.sv
// Testbench-side channel wrappers are not needed; the design interfaces are reused.
// This file holds a small package of bench-wide constants.
package qes_tb_pkg;

    // Idling profiles, in percent of cycles.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 75;
    localparam int IDLE_LIGHT = 12;

    // Pipeline latency at the default coefficient width.
    localparam int PIPE_LATENCY = 55;

endpackage

// File: bench/tb.sv
module tb;
    import qes_pkg::*;
    import qes_tb_pkg::*;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } coef_t;

    typedef struct packed {
        logic [31:0] r1;
        logic [31:0] i1;
        logic [31:0] r2;
        logic [31:0] i2;
        logic        cplx;
        logic [1:0]  st;
    } roots_t;

    logic clk;
    logic rst_n;

    qes_coef_if #(.COEF_WIDTH(16)) coef ();
    qes_root_if roots ();

    quadratic_equation_solver_unit #(.COEF_WIDTH(16)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef.sink),
        .roots (roots.source)
    );

    coef_t  pending_coefs[$];
    roots_t expected_roots[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;
    int     mismatches;
    int     idle_cycles;
    bit     stim_done;

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Quotient num*2^16/(2a), truncated toward zero and saturated to 32 bits.
    function automatic logic [31:0] fix_quot(longint num, longint a, inout bit sat);
        bit     neg;
        longint unsigned q;
        longint unsigned na;
        longint unsigned aa;
        neg = (num < 0) != (a < 0);
        na = (num < 0) ? -num : num;
        aa = (a < 0) ? -a : a;
        q = (na << 16) / (aa << 1);
        if (num == 0)
            return 32'd0;
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1'b1;
                q = 64'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            q = 64'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // Floor square root of a nonnegative value.
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        root = 0;
        rem = 0;
        for (int i = 31; i >= 0; i--)
        begin
            rem = (rem << 2) | ((x >> (2 * i)) & 3);
            trial = (root << 2) | 1;
            if (rem >= trial)
            begin
                rem -= trial;
                root = (root << 1) | 1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // Predict the roots of one coefficient triple.
    function automatic roots_t solve_roots(coef_t k);
        roots_t r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint s;
        bit     sat;
        r = '0;
        sat = 1'b0;
        a = k.a;
        b = k.b;
        c = k.c;
        if (a == 0)
        begin
            r.st = STATUS_A_ZERO;
            return r;
        end
        disc = b * b - 4 * a * c;
        s = longint'(floor_sqrt(disc < 0 ? -disc : disc));
        if (disc < 0)
        begin
            r.r1 = fix_quot(-b, a, sat);
            r.i1 = fix_quot(s, a, sat);
            r.r2 = r.r1;
            r.i2 = fix_quot(-s, a, sat);
            r.cplx = 1'b1;
        end
        else
        begin
            r.r1 = fix_quot(-b + s, a, sat);
            r.r2 = fix_quot(-b - s, a, sat);
        end
        r.st = sat ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    // Coefficient with a bias toward extremes and small values.
    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            3: return 16'($signed($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    // Driver: offers the next pending transaction, with random idling.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef.valid  <= 1'b0;
            coef.coef_a <= '0;
            coef.coef_b <= '0;
            coef.coef_c <= '0;
        end
        else
        begin
            if (coef.valid && coef.ready)
            begin
                expected_roots.push_back(solve_roots(pending_coefs.pop_front()));
            end
            if ((!coef.valid || coef.ready) && pending_coefs.size() > 0)
            begin
                if (($urandom_range(1, 100) > send_idle_pct))
                begin
                    coef.valid  <= 1'b1;
                    coef.coef_a <= pending_coefs[0].a;
                    coef.coef_b <= pending_coefs[0].b;
                    coef.coef_c <= pending_coefs[0].c;
                end
                else
                    coef.valid <= 1'b0;
            end
            else if (!coef.valid || coef.ready)
                coef.valid <= 1'b0;
        end
    end

    // Receiver ready, with random stalls and the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            roots.ready <= 1'b0;
        else
            roots.ready <= !hold_off && ($urandom_range(1, 100) > recv_stall_pct);
    end

    // Monitor: compares each returned transaction with the oldest prediction.
    always @(posedge clk)
    begin
        roots_t want;
        roots_t got;
        if (rst_n && roots.valid && roots.ready)
        begin
            got = {roots.first_root_real, roots.first_root_imag, roots.second_root_real,
                   roots.second_root_imag, roots.complex_pair, roots.status};
            if (expected_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected roots transaction %p", got);
            end
            else
            begin
                want = expected_roots.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Roots mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((coef.valid && coef.ready) || (roots.valid && roots.ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    task automatic hold_receiver(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_coefs.size() > 0 || coef.valid) && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    initial
    begin
        coef_t k;
        int    directed[$];
        rst_n = 1'b0;
        send_idle_pct = IDLE_NONE;
        recv_stall_pct = IDLE_NONE;
        hold_off = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        coef.valid = 1'b0;
        coef.coef_a = '0;
        coef.coef_b = '0;
        coef.coef_c = '0;
        roots.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero leading coefficient, extremes, real and complex pairs, saturation.
        pending_coefs.push_back('{16'sh0000, 16'sh0100, 16'sh0100});
        pending_coefs.push_back('{16'sh0000, 16'sh7FFF, 16'sh8000});
        pending_coefs.push_back('{16'sh0100, 16'sh0000, 16'shFF00});
        pending_coefs.push_back('{16'sh0100, 16'sh0000, 16'sh0100});
        pending_coefs.push_back('{16'shFF00, 16'sh0000, 16'shFF00});
        pending_coefs.push_back('{16'sh0100, 16'sh0200, 16'sh0100});
        pending_coefs.push_back('{16'sh0001, 16'sh7FFF, 16'sh7FFF});
        pending_coefs.push_back('{16'sh0001, 16'sh8000, 16'sh8000});
        pending_coefs.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
        pending_coefs.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        pending_coefs.push_back('{16'sh8000, 16'sh7FFF, 16'sh7FFF});
        pending_coefs.push_back('{16'shFFFF, 16'sh0000, 16'sh7FFF});
        pending_coefs.push_back('{16'sh0001, 16'sh0000, 16'sh7FFF});
        pending_coefs.push_back('{16'sh7FFF, 16'sh0000, 16'sh0000});
        pending_coefs.push_back('{16'shFFFF, 16'sh0001, 16'sh0000});
        pending_coefs.push_back('{16'sh0100, 16'shFD00, 16'sh0200});
        drain();

        // Random phases: none, sender idle, receiver stall, both light.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? IDLE_HEAVY : (phase == 3) ? IDLE_LIGHT : IDLE_NONE;
            recv_stall_pct = (phase == 2) ? IDLE_HEAVY : (phase == 3) ? IDLE_LIGHT : IDLE_NONE;
            for (int n = 0; n < 170; n++)
            begin
                k.a = rand_coef();
                k.b = rand_coef();
                k.c = rand_coef();
                pending_coefs.push_back(k);
            end
            if (phase == 0)
                hold_receiver(300);
            drain();
        end

        stim_done = 1'b1;
        begin
            int guard;
            guard = 0;
            while (expected_roots.size() > 0 && guard < 200000)
            begin
                @(posedge clk);
                guard++;
            end
        end
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
